// ----- src/lcd4_pkg.sv -----
// Shared types, codes and constants of the 4-bit character LCD sequencer.
package lcd4_pkg;

    // Request codes carried by the mode field
    localparam logic [2:0] MODE_TICK = 3'd0;
    localparam logic [2:0] MODE_CMD  = 3'd1;
    localparam logic [2:0] MODE_DATA = 3'd2;
    localparam logic [2:0] MODE_READ = 3'd3;
    localparam logic [2:0] MODE_NIB  = 3'd4;
    localparam logic [2:0] MODE_INIT = 3'd5;

    // Configuration register indexes (byte address is four times the index)
    localparam logic [2:0] REG_SETTLE_WAIT   = 3'd0;
    localparam logic [2:0] REG_CLEAR_WAIT    = 3'd1;
    localparam logic [2:0] REG_NIB_INIT_WAIT = 3'd2;
    localparam logic [2:0] REG_BUSY_RETRY    = 3'd3;
    localparam logic [2:0] REG_MAX_BUSY      = 3'd4;

    // Configuration reset values
    localparam logic [11:0] SETTLE_WAIT_RST   = 12'd37;
    localparam logic [15:0] CLEAR_WAIT_RST    = 16'd1520;
    localparam logic [11:0] NIB_INIT_WAIT_RST = 12'd160;
    localparam logic [11:0] BUSY_RETRY_RST    = 12'd37;
    localparam logic [3:0]  MAX_BUSY_RST      = 4'd8;

    // Command bytes and limits
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [3:0] INIT_LAST_STEP = 4'd8;
    localparam logic [3:0] INIT_NIB_STEPS = 4'd4;
    localparam logic [3:0] BUSY_CHECK_MAX = 4'd15;

    // Sequencer phases
    typedef enum logic [11:0] {
        PH_IDLE       = 12'b0000_0000_0001,
        PH_BUSY_A     = 12'b0000_0000_0010,
        PH_BUSY_B     = 12'b0000_0000_0100,
        PH_BUSY_WAIT  = 12'b0000_0000_1000,
        PH_WR_HI      = 12'b0000_0001_0000,
        PH_WR_LO      = 12'b0000_0010_0000,
        PH_POST_WAIT  = 12'b0000_0100_0000,
        PH_NIB        = 12'b0000_1000_0000,
        PH_NIB_WAIT   = 12'b0001_0000_0000,
        PH_NIB_SETTLE = 12'b0010_0000_0000,
        PH_RD_HI      = 12'b0100_0000_0000,
        PH_RD_LO      = 12'b1000_0000_0000
    } phase_t;

    // Configuration registers as seen by the sequencer
    typedef struct packed {
        logic [11:0] settle_wait;
        logic [15:0] clear_wait;
        logic [11:0] nibble_init_wait;
        logic [11:0] busy_retry_wait;
        logic [3:0]  max_busy_checks;
    } cfg_t;

    // One input item
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] value;
        logic [3:0] db_in;
    } item_t;

    // One result item
    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       enable;
        logic [3:0] db_out;
        logic       db_drive;
        logic       ready_res;
        logic       refused;
        logic       address_valid;
        logic [6:0] address;
    } res_t;

    // Power-on sequence: four initial nibbles, then five commands
    function automatic logic [7:0] init_byte(input logic [3:0] step);
        case (step)
            4'd0:    init_byte = 8'h30;
            4'd1:    init_byte = 8'h30;
            4'd2:    init_byte = 8'h30;
            4'd3:    init_byte = 8'h20;
            4'd4:    init_byte = 8'h28;
            4'd5:    init_byte = 8'h10;
            4'd6:    init_byte = 8'h0C;
            4'd7:    init_byte = 8'h06;
            default: init_byte = 8'h01;
        endcase
    endfunction

endpackage

// ----- src/lcd4_cfg.sv -----
// APB-style configuration register file of the LCD sequencer.
module lcd4_cfg
    import lcd4_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write the addressed register, ignore addresses beyond the list
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_SETTLE_WAIT:   cfg_next.settle_wait      = pwdata[11:0];
                REG_CLEAR_WAIT:    cfg_next.clear_wait       = pwdata[15:0];
                REG_NIB_INIT_WAIT: cfg_next.nibble_init_wait = pwdata[11:0];
                REG_BUSY_RETRY:    cfg_next.busy_retry_wait  = pwdata[11:0];
                REG_MAX_BUSY:      cfg_next.max_busy_checks  = pwdata[3:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_wait      <= SETTLE_WAIT_RST;
            cfg_reg.clear_wait       <= CLEAR_WAIT_RST;
            cfg_reg.nibble_init_wait <= NIB_INIT_WAIT_RST;
            cfg_reg.busy_retry_wait  <= BUSY_RETRY_RST;
            cfg_reg.max_busy_checks  <= MAX_BUSY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register, zero-extended
    always_comb begin
        case (reg_idx)
            REG_SETTLE_WAIT:   prdata = 32'(cfg_reg.settle_wait);
            REG_CLEAR_WAIT:    prdata = 32'(cfg_reg.clear_wait);
            REG_NIB_INIT_WAIT: prdata = 32'(cfg_reg.nibble_init_wait);
            REG_BUSY_RETRY:    prdata = 32'(cfg_reg.busy_retry_wait);
            REG_MAX_BUSY:      prdata = 32'(cfg_reg.max_busy_checks);
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ----- src/lcd4_seq.sv -----
// Sequencer state and single-tick next-state and pin logic of the LCD sequencer.
module lcd4_seq
    import lcd4_pkg::*;
#(
    parameter int DELAY_WIDTH = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step_en,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    localparam logic [DELAY_WIDTH-1:0] DLY_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [DELAY_WIDTH-1:0] delay_reg, delay_next;
    logic [7:0]             shift_reg, shift_next;
    logic [2:0]             kind_reg, kind_next;
    logic [3:0]             checks_reg, checks_next;
    logic [3:0]             step_reg, step_next;
    logic [7:0]             hold_reg, hold_next;

    // finish() target, worked out ahead of the advance
    phase_t     fin_phase;
    logic [7:0] fin_shift;
    logic [3:0] fin_step;
    logic [3:0] fin_checks;
    phase_t     cmd_phase;
    logic       in_wait;
    logic       leave_now;
    logic [1:0] sub;
    logic [3:0] nib;
    logic [15:0] post_len;

    // Clamp a wait length to what the delay counter holds
    function automatic logic [DELAY_WIDTH-1:0] sat_len(input logic [15:0] len);
        logic [31:0] wide;
        logic [31:0] lim;
        wide = 32'(len);
        lim  = 32'(DLY_MAX);
        if (wide > lim) begin
            sat_len = DLY_MAX;
        end else begin
            sat_len = wide[DELAY_WIDTH-1:0];
        end
    endfunction

    assign cmd_phase = (cfg.max_busy_checks == 4'd0) ? PH_WR_HI : PH_BUSY_A;

    always_comb begin
        phase_next  = phase_reg;
        delay_next  = delay_reg;
        shift_next  = shift_reg;
        kind_next   = kind_reg;
        checks_next = checks_reg;
        step_next   = step_reg;
        hold_next   = hold_reg;
        res         = '0;
        res.db_drive = 1'b1;
        fin_phase   = PH_IDLE;
        fin_shift   = shift_reg;
        fin_step    = step_reg;
        fin_checks  = checks_reg;
        in_wait     = 1'b0;
        leave_now   = 1'b0;
        nib         = 4'd0;
        post_len    = 16'd0;

        // Take a request when idle, drop it otherwise
        if (item.mode >= MODE_CMD && item.mode <= MODE_INIT) begin
            if (phase_reg != PH_IDLE) begin
                res.refused = 1'b1;
            end else begin
                kind_next  = item.mode;
                delay_next = '0;
                case (item.mode)
                    MODE_CMD, MODE_DATA: begin
                        shift_next  = item.value;
                        checks_next = 4'd0;
                        phase_next  = cmd_phase;
                    end
                    MODE_READ: begin
                        phase_next = PH_RD_HI;
                    end
                    MODE_NIB: begin
                        shift_next = item.value;
                        phase_next = PH_NIB;
                    end
                    default: begin
                        step_next  = 4'd0;
                        shift_next = init_byte(4'd0);
                        phase_next = PH_NIB;
                    end
                endcase
            end
        end

        // Drive the pins for this tick
        sub = delay_next[1:0];
        case (phase_next)
            PH_BUSY_A, PH_BUSY_B, PH_RD_HI, PH_RD_LO: begin
                res.rw       = 1'b1;
                res.db_drive = 1'b0;
                res.enable   = !sub[1];
                if (sub == 2'd1) begin
                    if (phase_next == PH_BUSY_A) begin
                        hold_next = {item.db_in, 4'd0};
                    end else if (phase_next == PH_RD_HI) begin
                        hold_next = {item.db_in, hold_reg[3:0]};
                    end else if (phase_next == PH_RD_LO) begin
                        hold_next = {hold_reg[7:4], item.db_in};
                    end
                end
                if (phase_next == PH_RD_LO && sub == 2'd3) begin
                    res.address_valid = 1'b1;
                    res.address       = hold_next[6:0];
                end
            end
            PH_WR_HI, PH_WR_LO, PH_NIB: begin
                res.rs     = (phase_next != PH_NIB) && (kind_next == MODE_DATA);
                res.enable = !sub[1];
                nib        = (phase_next == PH_WR_LO) ? shift_next[3:0] : shift_next[7:4];
                res.db_out = (sub == 2'd0) ? 4'd0 : nib;
            end
            default: begin
            end
        endcase

        // Next item of the power-on sequence, or back to idle
        if (kind_next == MODE_INIT && step_next < INIT_LAST_STEP) begin
            fin_step  = step_next + 4'd1;
            fin_shift = init_byte(fin_step);
            if (fin_step < INIT_NIB_STEPS) begin
                fin_phase = PH_NIB;
            end else begin
                fin_checks = 4'd0;
                fin_phase  = cmd_phase;
            end
        end else begin
            fin_step   = step_next;
            fin_shift  = shift_next;
            fin_checks = checks_next;
            fin_phase  = PH_IDLE;
        end

        // Advance the delay counter by one tick
        if (phase_next != PH_IDLE) begin
            in_wait = (phase_next == PH_BUSY_WAIT) || (phase_next == PH_POST_WAIT) ||
                      (phase_next == PH_NIB_WAIT) || (phase_next == PH_NIB_SETTLE);
            if (in_wait) begin
                if (delay_next != '0) begin
                    delay_next = delay_next - 1'b1;
                end
                leave_now = (delay_next == '0);
            end else begin
                delay_next = delay_next + 1'b1;
                leave_now  = (delay_next >= DELAY_WIDTH'(4));
            end
        end

        // Leave the phase, skipping any wait of zero ticks
        if (leave_now) begin
            case (phase_next)
                PH_BUSY_A: begin
                    phase_next = PH_BUSY_B;
                    delay_next = '0;
                end
                PH_BUSY_B: begin
                    if (hold_next[7]) begin
                        if (checks_next < BUSY_CHECK_MAX) begin
                            checks_next = checks_next + 4'd1;
                        end
                        if (cfg.busy_retry_wait == 12'd0) begin
                            phase_next = (checks_next < cfg.max_busy_checks) ?
                                         PH_BUSY_A : PH_WR_HI;
                            delay_next = '0;
                        end else begin
                            phase_next = PH_BUSY_WAIT;
                            delay_next = sat_len(16'(cfg.busy_retry_wait));
                        end
                    end else begin
                        phase_next = PH_WR_HI;
                        delay_next = '0;
                    end
                end
                PH_BUSY_WAIT: begin
                    phase_next = (checks_next < cfg.max_busy_checks) ? PH_BUSY_A : PH_WR_HI;
                    delay_next = '0;
                end
                PH_WR_HI: begin
                    phase_next = PH_WR_LO;
                    delay_next = '0;
                end
                PH_WR_LO: begin
                    post_len = (shift_next == CMD_CLEAR) ? cfg.clear_wait :
                               16'(cfg.settle_wait);
                    if (kind_next == MODE_DATA || post_len == 16'd0) begin
                        phase_next  = fin_phase;
                        delay_next  = '0;
                        shift_next  = fin_shift;
                        step_next   = fin_step;
                        checks_next = fin_checks;
                    end else begin
                        phase_next = PH_POST_WAIT;
                        delay_next = sat_len(post_len);
                    end
                end
                PH_NIB: begin
                    if (cfg.nibble_init_wait != 12'd0) begin
                        phase_next = PH_NIB_WAIT;
                        delay_next = sat_len(16'(cfg.nibble_init_wait));
                    end else if (cfg.settle_wait != 12'd0) begin
                        phase_next = PH_NIB_SETTLE;
                        delay_next = sat_len(16'(cfg.settle_wait));
                    end else begin
                        phase_next  = fin_phase;
                        delay_next  = '0;
                        shift_next  = fin_shift;
                        step_next   = fin_step;
                        checks_next = fin_checks;
                    end
                end
                PH_NIB_WAIT: begin
                    if (cfg.settle_wait != 12'd0) begin
                        phase_next = PH_NIB_SETTLE;
                        delay_next = sat_len(16'(cfg.settle_wait));
                    end else begin
                        phase_next  = fin_phase;
                        delay_next  = '0;
                        shift_next  = fin_shift;
                        step_next   = fin_step;
                        checks_next = fin_checks;
                    end
                end
                PH_RD_HI: begin
                    phase_next = PH_RD_LO;
                    delay_next = '0;
                end
                PH_POST_WAIT, PH_NIB_SETTLE, PH_RD_LO: begin
                    phase_next  = fin_phase;
                    delay_next  = '0;
                    shift_next  = fin_shift;
                    step_next   = fin_step;
                    checks_next = fin_checks;
                end
                default: begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                end
            endcase
        end

        res.ready_res = (phase_next == PH_IDLE);
    end

    // Hold the state unless an item is processed this cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            delay_reg  <= '0;
            shift_reg  <= 8'd0;
            kind_reg   <= 3'd0;
            checks_reg <= 4'd0;
            step_reg   <= 4'd0;
            hold_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            delay_reg  <= delay_next;
            shift_reg  <= shift_next;
            kind_reg   <= kind_next;
            checks_reg <= checks_next;
            step_reg   <= step_next;
            hold_reg   <= hold_next;
        end
    end

    // A wait phase never sits on an expired count
    a_wait_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BUSY_WAIT || phase_reg == PH_POST_WAIT ||
         phase_reg == PH_NIB_WAIT || phase_reg == PH_NIB_SETTLE) |-> (delay_reg != '0))
        else $error("wait phase with zero delay count");

    // A transfer slot lasts four ticks at most
    a_slot_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BUSY_A || phase_reg == PH_BUSY_B || phase_reg == PH_WR_HI ||
         phase_reg == PH_WR_LO || phase_reg == PH_NIB || phase_reg == PH_RD_HI ||
         phase_reg == PH_RD_LO) |-> (delay_reg < DELAY_WIDTH'(4)))
        else $error("slot tick count out of range");

    // A request taken while idle leaves idle on the next cycle
    a_request_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && phase_reg == PH_IDLE && item.mode >= MODE_CMD && item.mode <= MODE_INIT)
        |=> (phase_reg != PH_IDLE))
        else $error("accepted request did not start the sequencer");

    // No tick, no movement
    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> ($stable(phase_reg) && $stable(delay_reg)))
        else $error("sequencer moved without an item");

    // An address is reported only on the last tick of the low read slot
    a_addr_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && res.address_valid) |=> (phase_reg != PH_RD_LO))
        else $error("address read slot did not end");

endmodule

// ----- src/char_lcd_4bit_bus_sequencer_top.sv -----
// Top level of the 4-bit character LCD sequencer: item and result registers.
//
// Each input item (s_mode, s_value, s_db_in) is one microsecond tick of the
// display bus. It may carry a request: command byte, data byte, address read,
// single initial nibble or the whole power-on sequence. Each item gives
// exactly one result item with the pin levels for that tick (m_rs, m_rw,
// m_enable, m_db_out, m_db_drive) and status (m_ready_res, m_refused,
// m_address_valid, m_address). A request that arrives while the sequencer
// is busy is dropped and flagged with m_refused.
// Items pass through the item register and the tick logic into the result
// register, one item per cycle while the receiver takes every result.
// Reset (aresetn low at a clock edge) empties both registers, puts the
// sequencer in idle and loads the configuration defaults.
// When the receiver stalls, the held result waits in the result register
// and one more item is taken into the item register; s_ready then drops.
// The five wait and limit registers are to be written through the APB port
// only while idle; the block itself does not enforce this.
module char_lcd_4bit_bus_sequencer_top
    import lcd4_pkg::*;
#(
    parameter int DELAY_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_value,
    input  logic [3:0]  s_db_in,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_rs,
    output logic        m_rw,
    output logic        m_enable,
    output logic [3:0]  m_db_out,
    output logic        m_db_drive,
    output logic        m_ready_res,
    output logic        m_refused,
    output logic        m_address_valid,
    output logic [6:0]  m_address,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic  in_valid_reg, in_valid_next;
    item_t item_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  res_reg;
    res_t  res_comb;
    cfg_t  cfg;
    logic  out_free;
    logic  step_en;
    logic  take_in;

    lcd4_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcd4_seq #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res_comb)
    );

    // Handshake: process the held item when the result slot frees up
    assign out_free = !out_valid_reg || m_ready;
    assign step_en  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign take_in  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take_in) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the item and the result payloads
    always_ff @(posedge aclk) begin
        if (take_in) begin
            item_reg.mode  <= s_mode;
            item_reg.value <= s_value;
            item_reg.db_in <= s_db_in;
        end
        if (step_en) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_rs            = res_reg.rs;
    assign m_rw            = res_reg.rw;
    assign m_enable        = res_reg.enable;
    assign m_db_out        = res_reg.db_out;
    assign m_db_drive      = res_reg.db_drive;
    assign m_ready_res     = res_reg.ready_res;
    assign m_refused       = res_reg.refused;
    assign m_address_valid = res_reg.address_valid;
    assign m_address       = res_reg.address;

endmodule

// ----- tb/sv/lcd_bus_check_pkg.sv -----
// Pin-level predictor and result scoreboard for the 4-bit character LCD sequencer.
`timescale 1ns / 100ps

package lcd_bus_check_pkg;
    import lcd4_pkg::*;

    // Largest count the 16-bit delay counter holds
    localparam int unsigned DELAY_MAX = 32'h0000_FFFF;

    class lcd_bus_scoreboard;
        int errors;
        int results_seen;
        res_t pin_levels_q[$];

        // Local copy of the wait registers
        logic [11:0] settle_wait;
        logic [15:0] clear_wait;
        logic [11:0] nib_init_wait;
        logic [11:0] busy_retry_wait;
        logic [3:0]  max_busy;

        // Sequencer state
        phase_t      ph;
        int unsigned dly;
        logic [7:0]  sbyte;
        logic [2:0]  kind;
        logic [3:0]  bchk;
        logic [3:0]  istep;
        logic [7:0]  rhold;
        logic [7:0]  power_on_bytes [9];

        function new();
            power_on_bytes = '{8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h10, 8'h0C, 8'h06,
                               CMD_CLEAR};
            settle_wait     = SETTLE_WAIT_RST;
            clear_wait      = CLEAR_WAIT_RST;
            nib_init_wait   = NIB_INIT_WAIT_RST;
            busy_retry_wait = BUSY_RETRY_RST;
            max_busy        = MAX_BUSY_RST;
            ph    = PH_IDLE;
            dly   = 0;
            sbyte = '0;
            kind  = '0;
            bchk  = '0;
            istep = '0;
            rhold = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_SETTLE_WAIT:   settle_wait     = data[11:0];
                REG_CLEAR_WAIT:    clear_wait      = data[15:0];
                REG_NIB_INIT_WAIT: nib_init_wait   = data[11:0];
                REG_BUSY_RETRY:    busy_retry_wait = data[11:0];
                REG_MAX_BUSY:      max_busy        = data[3:0];
                default: ;
            endcase
        endfunction

        function bit seq_idle();
            return ph == PH_IDLE;
        endfunction

        function int pending();
            return pin_levels_q.size();
        endfunction

        function bit waiting_phase(phase_t p);
            return p == PH_BUSY_WAIT || p == PH_POST_WAIT || p == PH_NIB_WAIT ||
                   p == PH_NIB_SETTLE;
        endfunction

        function void enter_wait(phase_t p, int unsigned len);
            ph  = p;
            dly = (len > DELAY_MAX) ? DELAY_MAX : len;
        endfunction

        function void enter_slot(phase_t p);
            ph  = p;
            dly = 0;
        endfunction

        // Busy polling is skipped entirely when no busy read is allowed
        function void start_cmd(logic [7:0] b);
            sbyte = b;
            bchk  = '0;
            if (max_busy == 0) enter_slot(PH_WR_HI);
            else enter_slot(PH_BUSY_A);
        endfunction

        // Early power-on steps are bare nibbles, later ones full commands
        function void start_init_item();
            logic [3:0] s;
            s = (istep <= INIT_LAST_STEP) ? istep : INIT_LAST_STEP;
            if (s < INIT_NIB_STEPS) begin
                sbyte = power_on_bytes[s];
                enter_slot(PH_NIB);
            end else begin
                start_cmd(power_on_bytes[s]);
            end
        endfunction

        function void close_request();
            if (kind == MODE_INIT && istep < INIT_LAST_STEP) begin
                istep++;
                start_init_item();
            end else begin
                ph  = PH_IDLE;
                dly = 0;
            end
        endfunction

        function void advance_once();
            case (ph)
                PH_BUSY_A: enter_slot(PH_BUSY_B);
                PH_BUSY_B: begin
                    if (rhold[7]) begin
                        if (bchk < BUSY_CHECK_MAX) bchk++;
                        enter_wait(PH_BUSY_WAIT, busy_retry_wait);
                    end else begin
                        enter_slot(PH_WR_HI);
                    end
                end
                PH_BUSY_WAIT: begin
                    if (bchk < max_busy) enter_slot(PH_BUSY_A);
                    else enter_slot(PH_WR_HI);
                end
                PH_WR_HI: enter_slot(PH_WR_LO);
                PH_WR_LO: begin
                    if (kind == MODE_DATA) close_request();
                    else if (sbyte == CMD_CLEAR) enter_wait(PH_POST_WAIT, clear_wait);
                    else enter_wait(PH_POST_WAIT, settle_wait);
                end
                PH_NIB:      enter_wait(PH_NIB_WAIT, nib_init_wait);
                PH_NIB_WAIT: enter_wait(PH_NIB_SETTLE, settle_wait);
                PH_RD_HI:    enter_slot(PH_RD_LO);
                PH_POST_WAIT, PH_NIB_SETTLE, PH_RD_LO: close_request();
                default: begin
                    ph  = PH_IDLE;
                    dly = 0;
                end
            endcase
        endfunction

        // Skip over any wait of zero length straight away
        function void advance();
            advance_once();
            while (waiting_phase(ph) && dly == 0) advance_once();
        endfunction

        function res_t predict_pins(item_t it);
            res_t r;
            logic [1:0] sub;
            logic [3:0] nib;
            r = '0;
            r.db_drive = 1'b1;

            // Accept or drop a request
            if (it.mode >= MODE_CMD && it.mode <= MODE_INIT) begin
                if (ph != PH_IDLE) begin
                    r.refused = 1'b1;
                end else begin
                    kind = it.mode;
                    case (it.mode)
                        MODE_CMD, MODE_DATA: start_cmd(it.value);
                        MODE_READ: enter_slot(PH_RD_HI);
                        MODE_NIB: begin
                            sbyte = it.value;
                            enter_slot(PH_NIB);
                        end
                        default: begin
                            istep = '0;
                            start_init_item();
                        end
                    endcase
                end
            end

            // Pin levels for this tick
            sub = dly[1:0];
            case (ph)
                PH_BUSY_A, PH_BUSY_B, PH_RD_HI, PH_RD_LO: begin
                    r.rw       = 1'b1;
                    r.db_drive = 1'b0;
                    r.enable   = sub < 2;
                    if (sub == 2'd1) begin
                        if (ph == PH_BUSY_A) rhold = {it.db_in, 4'h0};
                        else if (ph == PH_RD_HI) rhold = {it.db_in, rhold[3:0]};
                        else if (ph == PH_RD_LO) rhold = {rhold[7:4], it.db_in};
                    end
                    if (ph == PH_RD_LO && sub == 2'd3) begin
                        r.address_valid = 1'b1;
                        r.address       = rhold[6:0];
                    end
                end
                PH_WR_HI, PH_WR_LO, PH_NIB: begin
                    r.rs     = (ph != PH_NIB) && (kind == MODE_DATA);
                    r.enable = sub < 2;
                    nib      = (ph == PH_WR_LO) ? sbyte[3:0] : sbyte[7:4];
                    r.db_out = (sub == 2'd0) ? 4'h0 : nib;
                end
                default: ;
            endcase

            // Advance the delay counter and the sequencer
            if (ph != PH_IDLE) begin
                if (waiting_phase(ph)) begin
                    if (dly > 0) dly--;
                    if (dly == 0) advance();
                end else begin
                    dly++;
                    if (dly >= 4) advance();
                end
            end
            r.ready_res = ph == PH_IDLE;
            return r;
        endfunction

        function void note_tick(item_t it);
            pin_levels_q.push_back(predict_pins(it));
        endfunction

        task report(string msg);
            errors++;
            // keep the log short when the block is badly off
            if (errors <= 200) $display("MISMATCH: %s", msg);
        endtask

        task cmp(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s: got %0h, expected %0h",
                                 results_seen, name, got, want));
        endtask

        task check_pins(res_t got);
            res_t want;
            results_seen++;
            if (pin_levels_q.size() == 0) begin
                report($sformatf("result %0d arrived with no tick pending", results_seen));
                return;
            end
            want = pin_levels_q.pop_front();
            cmp("rs", got.rs, want.rs);
            cmp("rw", got.rw, want.rw);
            cmp("enable", got.enable, want.enable);
            cmp("db_out", got.db_out, want.db_out);
            cmp("db_drive", got.db_drive, want.db_drive);
            cmp("ready_res", got.ready_res, want.ready_res);
            cmp("refused", got.refused, want.refused);
            cmp("address_valid", got.address_valid, want.address_valid);
            cmp("address", got.address, want.address);
        endtask

        task flush_check();
            if (pin_levels_q.size() != 0)
                report($sformatf("%0d ticks left without a result", pin_levels_q.size()));
        endtask
    endclass

endpackage

// ----- tb/sv/tb_char_lcd_4bit_bus_sequencer_top.sv -----
// Top-level testbench of the 4-bit character LCD sequencer: stimulus, idling and checks.
`timescale 1ns / 100ps

module tb_char_lcd_4bit_bus_sequencer_top;
    import lcd4_pkg::*;
    import lcd_bus_check_pkg::*;

    // Modes the block treats as plain ticks
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam int END_SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES     = 4;
    localparam int ITEMS_PER_PHASE   = 60;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_pattern_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_mode;
    logic [7:0]  s_value;
    logic [3:0]  s_db_in;
    logic        m_valid;
    logic        m_ready;
    logic        m_rs;
    logic        m_rw;
    logic        m_enable;
    logic [3:0]  m_db_out;
    logic        m_db_drive;
    logic        m_ready_res;
    logic        m_refused;
    logic        m_address_valid;
    logic [6:0]  m_address;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcd_bus_scoreboard sb;
    int burst_left;
    bit sender_gaps;
    int hold_req;
    int busy_pct;
    int db_force;

    char_lcd_4bit_bus_sequencer_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_value         (s_value),
        .s_db_in         (s_db_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rs            (m_rs),
        .m_rw            (m_rw),
        .m_enable        (m_enable),
        .m_db_out        (m_db_out),
        .m_db_drive      (m_db_drive),
        .m_ready_res     (m_ready_res),
        .m_refused       (m_refused),
        .m_address_valid (m_address_valid),
        .m_address       (m_address),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Pick the sampled data pins; DB7 follows the busy bias unless pinned
    function automatic logic [3:0] pick_db();
        logic [3:0] d;
        if (db_force >= 0) return 4'(db_force);
        d    = 4'($urandom);
        d[3] = $urandom_range(0, 99) < busy_pct;
        return d;
    endfunction

    // Offer one item in bursts with random gaps, hold it until taken
    task automatic send_item(input logic [2:0] mode, input logic [7:0] value,
                             input logic [3:0] db);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        s_db_in <= db;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick('{mode: mode, value: value, db_in: db});
    endtask

    task automatic tick();
        send_item(MODE_TICK, 8'($urandom), pick_db());
    endtask

    // Issue a request and tick until the sequencer is idle again
    task automatic request(input logic [2:0] mode, input logic [7:0] value);
        send_item(mode, value, pick_db());
        while (!sb.seq_idle()) tick();
    endtask

    // Finish the running request, then hold off until every result is in
    task automatic drain();
        while (!sb.seq_idle()) tick();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Unused upper bits carry noise, the block must ignore them
    task automatic set_config(input int unsigned settle, input int unsigned clear,
                              input int unsigned nib, input int unsigned retry,
                              input int unsigned maxb);
        drain();
        cfg_write(REG_SETTLE_WAIT,   {20'($urandom), 12'(settle)});
        cfg_write(REG_CLEAR_WAIT,    {16'($urandom), 16'(clear)});
        cfg_write(REG_NIB_INIT_WAIT, {20'($urandom), 12'(nib)});
        cfg_write(REG_BUSY_RETRY,    {20'($urandom), 12'(retry)});
        cfg_write(REG_MAX_BUSY,      {28'($urandom), 4'(maxb)});
    endtask

    // Receiver: stall patterns in stretches, plus long hold-offs on request
    initial begin
        int stretch_left;
        int hold_left;
        rx_pattern_t pattern;
        logic rdy;
        stretch_left = 0;
        hold_left    = 0;
        pattern      = RX_FREE;
        m_ready      = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(1, 150);
                pattern      = rx_pattern_t'($urandom_range(0, 2));
            end
            stretch_left--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (pattern)
                    RX_RANDOM:   rdy = $urandom_range(0, 99) >= 30;
                    RX_PERIODIC: rdy = (stretch_left % 3) != 0;
                    default:     rdy = 1'b1;
                endcase
            end
            m_ready <= rdy;
        end
    end

    // Check each result taken
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pins({m_rs, m_rw, m_enable, m_db_out, m_db_drive, m_ready_res,
                           m_refused, m_address_valid, m_address});
    end

    // Stimulus
    initial begin
        int r;
        logic [2:0] mode;
        logic [7:0] value;
        s_valid     = 1'b0;
        s_mode      = MODE_TICK;
        s_value     = '0;
        s_db_in     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        aresetn     = 1'b0;
        burst_left  = 0;
        sender_gaps = 1'b1;
        hold_req    = 0;
        busy_pct    = 50;
        db_force    = -1;
        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: address reads with all pins high and low, then a command and a data write
        db_force = 15;
        request(MODE_READ, 8'h00);
        db_force = 0;
        request(MODE_READ, 8'hFF);
        request(MODE_CMD, 8'h28);
        request(MODE_DATA, 8'h00);

        // Short waits keep the directed requests brief
        set_config(2, 5, 3, 1, 2);
        // display stays busy: poll to the limit, then write anyway
        db_force = 15;
        request(MODE_DATA, 8'hFF);
        db_force = 0;
        request(MODE_DATA, 8'h00);
        db_force = -1;
        request(MODE_NIB, 8'hA5);
        request(MODE_CMD, CMD_CLEAR);

        // Requests while busy are dropped; spare modes act as plain ticks
        send_item(MODE_CMD, 8'h0C, pick_db());
        send_item(MODE_DATA, 8'h55, pick_db());
        send_item(MODE_INIT, 8'h00, pick_db());
        send_item(MODE_SPARE_6, 8'hFF, pick_db());
        while (!sb.seq_idle()) tick();
        send_item(MODE_SPARE_6, 8'h00, pick_db());
        send_item(MODE_SPARE_7, 8'hFF, pick_db());
        db_force = 0;
        request(MODE_INIT, 8'h00);

        // Zero waits are skipped and no busy read is made
        set_config(0, 0, 0, 0, 0);
        request(MODE_CMD, CMD_CLEAR);
        request(MODE_DATA, 8'h3C);
        request(MODE_NIB, 8'hF0);
        request(MODE_INIT, 8'h00);
        db_force = -1;
        request(MODE_READ, 8'h00);

        // One busy read allowed and a retry wait of zero; a busy display is then written anyway
        set_config(0, 0, 0, 0, 1);
        db_force = 15;
        request(MODE_CMD, 8'h80);

        // Longer waits and deepest polling
        set_config(10, 24, 6, 1, 15);
        db_force = 0;
        request(MODE_CMD, CMD_CLEAR);
        request(MODE_NIB, 8'h30);
        db_force = 15;
        request(MODE_DATA, 8'h81);
        db_force = -1;

        // Random phases with short waits: mostly requests while idle
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_config($urandom_range(0, 12), $urandom_range(0, 40), $urandom_range(0, 12),
                       $urandom_range(0, 8), $urandom_range(0, 15));
            busy_pct = $urandom_range(0, 100);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // stall the receiver for a long stretch while items keep coming
                if (p == 1 && n == 15) begin
                    sender_gaps = 1'b0;
                    burst_left  = 0;
                    hold_req    = 120;
                end
                if (p == 1 && n == 45) sender_gaps = 1'b1;
                r = $urandom_range(0, 99);
                if (sb.seq_idle()) begin
                    if (r < 20) mode = MODE_TICK;
                    else if (r < 23) mode = r[0] ? MODE_SPARE_6 : MODE_SPARE_7;
                    else if (r < 43) mode = MODE_CMD;
                    else if (r < 65) mode = MODE_DATA;
                    else if (r < 80) mode = MODE_READ;
                    else if (r < 94) mode = MODE_NIB;
                    else mode = MODE_INIT;
                end else begin
                    if (r < 85) mode = MODE_TICK;
                    else if (r < 95) mode = 3'($urandom_range(MODE_CMD, MODE_INIT));
                    else mode = r[0] ? MODE_SPARE_6 : MODE_SPARE_7;
                end
                value = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : 8'($urandom);
                send_item(mode, value, pick_db());
            end
        end

        drain();
        repeat (END_SETTLE_CYCLES) @(posedge aclk);
        sb.flush_check();
        if (sb.errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #60ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
